// ===== src/twcw_pkg.sv =====
// shared types and constants of the text cleaner and word wrapper
`timescale 1ns / 1ps
`default_nettype none

package twcw_pkg;

  // one text byte
  typedef logic [7:0] char_t;

  // printable ascii range, the space being its lowest code
  localparam char_t SpaceChar     = 8'h20;
  localparam char_t LastPrintable = 8'h7E;

  // width of the line number and line count on the result port
  localparam int LineIdxW = 6;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_NEXT = 6'b000010,
    S_PUSH = 6'b000100,
    S_RD   = 6'b001000,
    S_LD   = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== src/twcw_window_ram.sv =====
// line window storage: one write port, one read port, registered read data
`timescale 1ns / 1ps
`default_nettype none

module twcw_window_ram #(
  parameter int Depth = 22,
  parameter int AddrW = 5
) (
  input  wire                   clk_i,
  input  wire                   we_i,
  input  wire [AddrW-1:0]       waddr_i,
  input  wire twcw_pkg::char_t  wdata_i,
  input  wire                   re_i,
  input  wire [AddrW-1:0]       raddr_i,
  output twcw_pkg::char_t       rdata_o
);
  import twcw_pkg::*;

  char_t mem_q [Depth];
  char_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/text_clean_and_word_wrap.sv =====
// text cleaner and greedy word wrapper, top level
//
// Input channel (in_valid_i / in_ready_o) takes one raw message byte per
// request with a last-byte flag. Printable bytes are kept, space runs
// collapse, a zero byte ends the text. Kept characters go into a circular
// line window held in a small synchronous RAM; when the window holds
// LINE_WIDTH+1 characters a line is cut at the last space (or hard) and its
// characters leave on the output channel (out_valid_o / out_ready_i), one
// request per character. After the last byte the remainder leaves as a final
// line, followed by a done marker carrying the line count.
// Items are taken one at a time: a byte is decoded, then written into the
// window with up to two writes (a pending space, then the character); each
// line character is read from the RAM and then loaded into the output
// register; the done marker is loaded into the output register directly.
// A stalled receiver holds the output register and stops the sequencer at
// its next output load; no input is taken until all results of the current
// byte have been loaded.
// Reset clears all control state; the window RAM needs no clearing, since
// only entries written for the current line are ever read.
`timescale 1ns / 1ps
`default_nettype none

module text_clean_and_word_wrap #(
  parameter int LINE_WIDTH      = 21,
  parameter int MAX_LINES       = 60,
  parameter int MAX_MESSAGE_LEN = 512
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire twcw_pkg::char_t     char_in_i,
  input  wire                      last_byte_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output twcw_pkg::char_t          out_char_o,
  output logic                     is_char_o,
  output logic                     line_end_o,
  output logic [twcw_pkg::LineIdxW-1:0] line_index_o,
  output logic                     message_done_o,
  output logic [twcw_pkg::LineIdxW-1:0] line_count_o
);
  import twcw_pkg::*;

  localparam int W   = LINE_WIDTH + 1;
  localparam int AW  = $clog2(W);
  localparam int PW  = $clog2(W + 1);
  localparam int KW  = $clog2(MAX_MESSAGE_LEN);
  localparam int LNW = $clog2(MAX_LINES + 1);

  // circular add of a window offset to a pointer
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = (PW+1)'(base) + (PW+1)'(off);
    if (sum >= (PW+1)'(W)) begin
      sum = sum - (PW+1)'(W);
    end
    return sum[AW-1:0];
  endfunction

  // control and window state
  state_e          state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [PW-1:0]   fill_q, fill_d;
  logic            sp_vld_q, sp_vld_d;
  logic [PW-1:0]   sp_pos_q, sp_pos_d;
  logic            pend_q, pend_d;
  logic [KW-1:0]   kept_q, kept_d;
  logic [LNW-1:0]  lines_q, lines_d;
  logic            ended_q, ended_d;

  // current request
  char_t           char_q, char_d;
  logic            last_q, last_d;
  logic            push_sp_q, push_sp_d;
  logic            do_char_q, do_char_d;

  // line emission
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]   n_q, n_d;
  logic [PW-1:0]   i_q, i_d;
  logic [LineIdxW-1:0] line_q, line_d;
  logic            flush_q, flush_d;

  // output register
  logic            out_valid_q;
  logic            out_load;
  logic            out_free;
  char_t           out_char_d;
  logic            is_char_d, line_end_d, message_done_d;
  logic [LineIdxW-1:0] line_index_d, line_count_d;

  // ram port signals
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr;
  char_t           mem_wdata;
  char_t           mem_rdata;

  // push and break helpers
  logic            sp_hit, eff_vld, brk;
  logic [PW-1:0]   eff_pos, fill_inc, cut_len, drop_len, i_inc;

  twcw_window_ram #(
    .Depth (W),
    .AddrW (AW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // break point of a full window
  always_comb begin
    mem_wdata = push_sp_q ? SpaceChar : char_q;
    mem_waddr = wrap_add(head_q, fill_q);
    fill_inc  = fill_q + PW'(1);
    sp_hit    = (mem_wdata == SpaceChar) && (fill_q != '0);
    eff_vld   = sp_hit || sp_vld_q;
    eff_pos   = sp_hit ? fill_q : sp_pos_q;
    brk       = (fill_inc == PW'(W));
    cut_len   = eff_vld ? eff_pos : PW'(LINE_WIDTH);
    drop_len  = eff_vld ? (eff_pos + PW'(1)) : PW'(LINE_WIDTH);
    i_inc     = i_q + PW'(1);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    sp_vld_d  = sp_vld_q;
    sp_pos_d  = sp_pos_q;
    pend_d    = pend_q;
    kept_d    = kept_q;
    lines_d   = lines_q;
    ended_d   = ended_q;
    char_d    = char_q;
    last_d    = last_q;
    push_sp_d = push_sp_q;
    do_char_d = do_char_q;
    rd_ptr_d  = rd_ptr_q;
    n_d       = n_q;
    i_d       = i_q;
    line_d    = line_q;
    flush_d   = flush_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load       = 1'b0;
    out_char_d     = mem_rdata;
    is_char_d      = 1'b1;
    line_end_d     = (i_inc == n_q);
    line_index_d   = line_q;
    message_done_d = 1'b0;
    line_count_d   = '0;

    unique case (state_q)
      // decode one request
      S_IDLE: begin
        if (in_valid_i) begin
          char_d    = char_in_i;
          last_d    = last_byte_i;
          push_sp_d = 1'b0;
          do_char_d = 1'b0;
          if (!ended_q && char_in_i == '0) begin
            ended_d = 1'b1;
          end else if (!ended_q && kept_q < KW'(MAX_MESSAGE_LEN - 1) &&
                       char_in_i >= SpaceChar && char_in_i <= LastPrintable) begin
            if (char_in_i == SpaceChar) begin
              if (!pend_q) begin
                pend_d = 1'b1;
                kept_d = kept_q + KW'(1);
              end
            end else begin
              kept_d    = kept_q + KW'(1);
              push_sp_d = pend_q;
              pend_d    = 1'b0;
              do_char_d = 1'b1;
            end
          end
          state_d = S_NEXT;
        end
      end

      // pick the next step of this request
      S_NEXT: begin
        if (push_sp_q || do_char_q) begin
          state_d = S_PUSH;
        end else if (last_q) begin
          if (fill_q != '0 && lines_q < LNW'(MAX_LINES)) begin
            rd_ptr_d = head_q;
            n_d      = fill_q;
            i_d      = '0;
            line_d   = LineIdxW'(lines_q);
            lines_d  = lines_q + LNW'(1);
            flush_d  = 1'b1;
            state_d  = S_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      // write one character into the window, cut a line when full
      S_PUSH: begin
        mem_we = 1'b1;
        if (push_sp_q) begin
          push_sp_d = 1'b0;
        end else begin
          do_char_d = 1'b0;
        end
        if (brk) begin
          head_d   = wrap_add(head_q, drop_len);
          fill_d   = PW'(W) - drop_len;
          sp_vld_d = 1'b0;
          if (lines_q < LNW'(MAX_LINES)) begin
            rd_ptr_d = head_q;
            n_d      = cut_len;
            i_d      = '0;
            line_d   = LineIdxW'(lines_q);
            lines_d  = lines_q + LNW'(1);
            flush_d  = 1'b0;
            state_d  = S_RD;
          end else begin
            state_d = S_NEXT;
          end
        end else begin
          fill_d = fill_inc;
          if (sp_hit) begin
            sp_vld_d = 1'b1;
            sp_pos_d = fill_q;
          end
          state_d = S_NEXT;
        end
      end

      // read one line character
      S_RD: begin
        mem_re   = 1'b1;
        rd_ptr_d = wrap_add(rd_ptr_q, PW'(1));
        state_d  = S_LD;
      end

      // hand the character to the output register
      S_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          i_d      = i_inc;
          if (i_inc == n_q) begin
            state_d = flush_q ? S_DONE : S_NEXT;
          end else begin
            state_d = S_RD;
          end
        end
      end

      // done marker, then back to the empty message state
      S_DONE: begin
        out_char_d     = '0;
        is_char_d      = 1'b0;
        line_end_d     = 1'b0;
        line_index_d   = '0;
        message_done_d = 1'b1;
        line_count_d   = LineIdxW'(lines_q);
        if (out_free) begin
          out_load = 1'b1;
          head_d   = '0;
          fill_d   = '0;
          sp_vld_d = 1'b0;
          pend_d   = 1'b0;
          kept_d   = '0;
          lines_d  = '0;
          ended_d  = 1'b0;
          last_d   = 1'b0;
          flush_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      sp_vld_q  <= 1'b0;
      pend_q    <= 1'b0;
      kept_q    <= '0;
      lines_q   <= '0;
      ended_q   <= 1'b0;
      last_q    <= 1'b0;
      push_sp_q <= 1'b0;
      do_char_q <= 1'b0;
      rd_ptr_q  <= '0;
      n_q       <= '0;
      i_q       <= '0;
      flush_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      sp_vld_q  <= sp_vld_d;
      pend_q    <= pend_d;
      kept_q    <= kept_d;
      lines_q   <= lines_d;
      ended_q   <= ended_d;
      last_q    <= last_d;
      push_sp_q <= push_sp_d;
      do_char_q <= do_char_d;
      rd_ptr_q  <= rd_ptr_d;
      n_q       <= n_d;
      i_q       <= i_d;
      flush_q   <= flush_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    sp_pos_q <= sp_pos_d;
    line_q   <= line_d;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_o     <= out_char_d;
      is_char_o      <= is_char_d;
      line_end_o     <= line_end_d;
      line_index_o   <= line_index_d;
      message_done_o <= message_done_d;
      line_count_o   <= line_count_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // window never holds a full line plus one at rest
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= PW'(LINE_WIDTH))
    else $error("line window overfilled");

  // tracked space lies inside the window, past its first character
  a_space_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_vld_q |-> (sp_pos_q != '0 && sp_pos_q < fill_q))
    else $error("tracked space outside window");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while busy");

  // kept count stays within the message limit
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KW'(MAX_MESSAGE_LEN - 1))
    else $error("kept count past limit");

endmodule

`default_nettype wire
